### hdl/crit_pkg.sv
// shared types and constants for the cartridge register page
package crit_pkg;

  localparam int RamDepthDefault = 2048;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_RD   = 2'd1;
  localparam logic [1:0] ACT_WR   = 2'd2;
  localparam logic [1:0] ACT_BANK = 2'd3;

  localparam logic [1:0] ROUTE_LOCAL    = 2'd0;
  localparam logic [1:0] ROUTE_DISK     = 2'd1;
  localparam logic [1:0] ROUTE_DISK_IRQ = 2'd2;
  localparam logic [1:0] ROUTE_APU      = 2'd3;

  localparam logic [11:0] REG_DISK_LO    = 12'h040;
  localparam logic [11:0] REG_DISK_HI    = 12'h047;
  localparam logic [11:0] REG_TIMER_ON   = 12'h048;
  localparam logic [11:0] REG_TIMER_OFFA = 12'h049;
  localparam logic [11:0] REG_UNUSED_A   = 12'h04A;
  localparam logic [11:0] REG_TIMER_OFFB = 12'h04B;
  localparam logic [11:0] REG_IRQ_CTL    = 12'h04C;
  localparam logic [11:0] REG_UNUSED_D   = 12'h04D;
  localparam logic [11:0] REG_UNUSED_E   = 12'h04E;
  localparam logic [11:0] REG_UNUSED_F   = 12'h04F;

  localparam int RamSelBit  = 11;
  localparam int MaskTopBit = 23;
  localparam int MaskBase   = 7;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] addr;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] route;
    logic       irq_asserted;
    logic [6:0] prg_bank_out;
    logic       bios_bank_out;
  } rsp_t;

  typedef struct packed {
    logic [1:0] route;
    logic       irq;
    logic [6:0] prg_bank;
    logic       bios_bank;
  } stat_t;

endpackage

### hdl/cartridge_regs_irq_timer.sv
// cartridge register page: work ram, bank registers and irq timer
// two register stages: a taken request is held in stage s1, then moved into the output register as its response
// throughput: one request per cycle while the output is not stalled, set by the single-port work ram access
// a finished response waits in the output register while the next request enters
// reset clears banks, timer, mask, counter and irq; work ram is not cleared
module cartridge_regs_irq_timer #(
  parameter int RAM_DEPTH = crit_pkg::RamDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  crit_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output crit_pkg::rsp_t rsp
);

  logic            accept;
  logic            s1_valid;
  logic            s1_adv;
  logic            s1_ram_rd;
  crit_pkg::stat_t s1_stat;
  crit_pkg::stat_t stat_next;
  logic            ram_wr;
  logic            ram_rd;
  logic [7:0]      ram_q;

  assign s1_adv    = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s1_adv;
  assign accept    = req_valid && req_ready;
  assign ram_wr    = accept && req.action == crit_pkg::ACT_WR && req.addr[crit_pkg::RamSelBit];
  assign ram_rd    = accept && req.action == crit_pkg::ACT_RD && req.addr[crit_pkg::RamSelBit];

  crit_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .stat_next (stat_next)
  );

  crit_ram #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .rd_en   (ram_rd),
    .addr    (req.addr),
    .wr_data (req.data),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_stat   <= stat_next;
      s1_ram_rd <= ram_rd;
    end
    if (s1_adv && s1_valid) begin
      rsp.read_data     <= s1_ram_rd ? ram_q : 8'd0;
      rsp.route         <= s1_stat.route;
      rsp.irq_asserted  <= s1_stat.irq;
      rsp.prg_bank_out  <= s1_stat.prg_bank;
      rsp.bios_bank_out <= s1_stat.bios_bank;
    end
  end

endmodule

### hdl/crit_ram.sv
// work ram with address folding and registered read data
module crit_ram #(
  parameter int RAM_DEPTH = crit_pkg::RamDepthDefault
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic        rd_en,
  input  logic [11:0] addr,
  input  logic [7:0]  wr_data,
  output logic [7:0]  rd_data
);

  localparam int AW = $clog2(RAM_DEPTH);

  logic [7:0]    mem [RAM_DEPTH];
  logic [11:0]   ofs;
  logic [AW-1:0] idx;

  // fold the 11-bit offset into the memory depth, quotient below 16
  always_comb begin
    ofs = {1'b0, addr[10:0]};
    for (int k = 3; k >= 0; k--) begin
      if ({4'b0, ofs} >= 16'(RAM_DEPTH << k)) begin
        ofs = 12'({4'b0, ofs} - 16'(RAM_DEPTH << k));
      end
    end
    idx = ofs[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[idx];
    end
  end

endmodule

### hdl/crit_regs.sv
// bank registers, timer, irq and address decode
module crit_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  crit_pkg::req_t  req,
  output crit_pkg::stat_t stat_next
);

  logic [6:0]  prg_bank, prg_bank_next;
  logic        bios_bank, bios_bank_next;
  logic        timer_enable, timer_enable_next;
  logic [23:0] match_mask, match_mask_next;
  logic [23:0] cycle_count, cycle_count_next;
  logic        irq_level, irq_level_next;
  logic [23:0] count_inc;
  logic [1:0]  route;
  logic        is_ram;
  logic        is_disk;

  assign count_inc = cycle_count + 24'd1;
  assign is_ram    = req.addr[crit_pkg::RamSelBit];
  assign is_disk   = req.addr >= crit_pkg::REG_DISK_LO && req.addr <= crit_pkg::REG_DISK_HI;

  always_comb begin
    prg_bank_next     = prg_bank;
    bios_bank_next    = bios_bank;
    timer_enable_next = timer_enable;
    match_mask_next   = match_mask;
    cycle_count_next  = cycle_count;
    irq_level_next    = irq_level;
    route             = crit_pkg::ROUTE_LOCAL;
    unique case (req.action)
      crit_pkg::ACT_TICK: begin
        if ((cycle_count & match_mask) == 24'd0) begin
          cycle_count_next = count_inc;
          if ((count_inc & match_mask) != 24'd0 && timer_enable) begin
            irq_level_next = 1'b1;
          end
        end
      end
      crit_pkg::ACT_RD: begin
        if (is_ram) begin
          route = crit_pkg::ROUTE_LOCAL;
        end else if (is_disk) begin
          route = crit_pkg::ROUTE_DISK;
        end else if (req.addr == crit_pkg::REG_IRQ_CTL) begin
          route = crit_pkg::ROUTE_DISK_IRQ;
        end else begin
          route = crit_pkg::ROUTE_APU;
        end
      end
      crit_pkg::ACT_WR: begin
        if (is_ram) begin
          route = crit_pkg::ROUTE_LOCAL;
        end else if (is_disk) begin
          route = crit_pkg::ROUTE_DISK;
        end else begin
          unique case (req.addr)
            crit_pkg::REG_TIMER_ON: begin
              timer_enable_next = 1'b1;
              cycle_count_next  = 24'd0;
            end
            crit_pkg::REG_TIMER_OFFA, crit_pkg::REG_TIMER_OFFB: begin
              timer_enable_next = 1'b0;
              irq_level_next    = 1'b0;
            end
            crit_pkg::REG_IRQ_CTL: begin
              match_mask_next = 24'd1 << crit_pkg::MaskTopBit;
              irq_level_next  = 1'b0;
              if (req.data[3]) begin
                match_mask_next[5'(crit_pkg::MaskBase) + 5'(req.data[2:0])] = 1'b1;
                if (req.data[2:0] == 3'd0) begin
                  irq_level_next = 1'b1;
                end
              end
            end
            crit_pkg::REG_UNUSED_A, crit_pkg::REG_UNUSED_D,
            crit_pkg::REG_UNUSED_E, crit_pkg::REG_UNUSED_F: begin
              route = crit_pkg::ROUTE_LOCAL;
            end
            default: begin
              route = crit_pkg::ROUTE_APU;
            end
          endcase
        end
      end
      crit_pkg::ACT_BANK: begin
        if (req.addr[0]) begin
          bios_bank_next = req.data[0];
        end else begin
          prg_bank_next = req.data[6:0];
        end
      end
      default: begin
        route = crit_pkg::ROUTE_LOCAL;
      end
    endcase
  end

  assign stat_next.route     = route;
  assign stat_next.irq       = irq_level_next;
  assign stat_next.prg_bank  = prg_bank_next;
  assign stat_next.bios_bank = bios_bank_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank     <= '0;
      bios_bank    <= 1'b0;
      timer_enable <= 1'b0;
      match_mask   <= '0;
      cycle_count  <= '0;
      irq_level    <= 1'b0;
    end else if (accept) begin
      prg_bank     <= prg_bank_next;
      bios_bank    <= bios_bank_next;
      timer_enable <= timer_enable_next;
      match_mask   <= match_mask_next;
      cycle_count  <= cycle_count_next;
      irq_level    <= irq_level_next;
    end
  end

endmodule

### hdl/crit_chk.sv
// port checker for the cartridge register page and its bind
module crit_chk (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input crit_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input crit_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request refused without output stall");

  a_rd_local: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.read_data == 8'd0 || rsp.route == crit_pkg::ROUTE_LOCAL)
    else $error("read data on a routed access");

endmodule

bind cartridge_regs_irq_timer crit_chk u_chk (.*);
